>>> rtl/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg: shared types and constants of the page replacement table
// Holds sizes, outcome and policy codes, CSR indices, LFSR taps and the controller command and status structs.
// ----------------------------------------------------------------------------
package prt_pkg;

   localparam int PAGE_COUNT = 256;
   localparam int FRAMES     = 16;
   localparam int PAGE_W     = $clog2(PAGE_COUNT);
   localparam int FRAME_W    = $clog2(FRAMES);
   localparam int CNT_W      = $clog2(FRAMES + 1);
   localparam int AGE_W      = FRAME_W;

   localparam logic [1:0] OUT_HIT     = 2'd0;
   localparam logic [1:0] OUT_FILL    = 2'd1;
   localparam logic [1:0] OUT_REPLACE = 2'd2;

   localparam logic [1:0] POL_RANDOM = 2'd0;
   localparam logic [1:0] POL_FIFO   = 2'd1;

   localparam logic       CSR_POLICY = 1'b0;
   localparam logic       CSR_FRAMES = 1'b1;

   localparam logic [15:0] LFSR_TAPS = 16'hB400;

   typedef struct packed {
      logic load;     // capture request, start page table read
      logic decide;   // page table data valid, classify access
      logic div_step; // victim search: one restoring division step under random policy, load victim when done
      logic commit;   // update tables, load result register
   } prt_cmd_type;

   typedef struct packed {
      logic is_hit;
      logic is_fill;
      logic div_done;
   } prt_sts_type;

endpackage

>>> rtl/prt_ctrl.sv
// ----------------------------------------------------------------------------
// prt_ctrl: sequencer of the page replacement table
// Steps each reference through read, decide, victim search (replacements only) and commit.
// ----------------------------------------------------------------------------
module prt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 out_free,
   input  prt_pkg::prt_sts_type sts,
   output prt_pkg::prt_cmd_type cmd
);
   import prt_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_READ   = 5'b00010,
      S_DECIDE = 5'b00100,
      S_DIV    = 5'b01000,
      S_COMMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ:   state_in = S_DECIDE;
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = (sts.is_hit || sts.is_fill) ? S_COMMIT : S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

>>> rtl/prt_datapath.sv
// ----------------------------------------------------------------------------
// prt_datapath: tables and victim logic of the page replacement table
// Page table memory, frame owners, LRU ages, FIFO pointer, LFSR, result reg.
// ----------------------------------------------------------------------------
module prt_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [4:0]                 csr_wdata,
   input  logic [prt_pkg::PAGE_W-1:0] page_in,
   input  prt_pkg::prt_cmd_type       cmd,
   output prt_pkg::prt_sts_type       sts,
   output logic                       out_free,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [23:0]                rsp_tdata
);
   import prt_pkg::*;

   logic [1:0]            policy_ff;
   logic [4:0]            fcount_ff;
   logic [PAGE_COUNT-1:0] valid_ff;
   logic [FRAME_W-1:0]    pframe_mem [PAGE_COUNT];
   logic [FRAME_W-1:0]    pframe_rd_ff;
   logic [PAGE_W-1:0]     owner_ff [FRAMES];
   logic [AGE_W-1:0]      age_ff [FRAMES];
   logic [CNT_W-1:0]      used_ff;
   logic [FRAME_W-1:0]    fifo_ff;
   logic [15:0]           lfsr_ff;
   logic [PAGE_W-1:0]     page_ff;
   logic                  hit_ff, fill_ff;
   logic [FRAME_W-1:0]    frame_ff;
   // restoring divider for LFSR modulo frames_used
   logic [15:0]           dq_ff;
   logic [CNT_W-1:0]      drem_ff;
   logic [4:0]            dcnt_ff;
   logic                  rvalid_ff;
   logic [23:0]           rdata_ff;

   logic [CNT_W-1:0]      eff;
   logic [CNT_W-1:0]      fc_trim;
   logic [15:0]           lfsr_next;
   logic [CNT_W:0]        dtrial;
   logic [FRAME_W-1:0]    lru_v;
   logic [AGE_W-1:0]      lru_a;
   logic [FRAME_W-1:0]    victim;
   logic [FRAME_W-1:0]    hit_frame;
   logic [FRAME_W-1:0]    fifo_use;
   logic [1:0]            outcome;

   assign fc_trim = (fcount_ff > 5'(FRAMES)) ? CNT_W'(FRAMES) : CNT_W'(fcount_ff);
   assign eff     = (fcount_ff == 5'd0) ? CNT_W'(1) : fc_trim;
   assign lfsr_next = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_TAPS : 16'd0);
   assign dtrial  = {drem_ff, dq_ff[15]} - {1'b0, used_ff};
   assign hit_frame = pframe_rd_ff;
   assign fifo_use  = ({1'b0, fifo_ff} >= used_ff) ? '0 : fifo_ff;

   // LRU search, oldest occupied frame, lowest index on ties
   always_comb begin
      lru_v = '0;
      lru_a = age_ff[0];
      for (int g = 1; g < FRAMES; g++) begin
         if (CNT_W'(g) < used_ff && age_ff[g] > lru_a) begin
            lru_v = FRAME_W'(g);
            lru_a = age_ff[g];
         end
      end
   end

   always_comb begin
      case (policy_ff)
         POL_RANDOM: victim = drem_ff[FRAME_W-1:0];
         POL_FIFO:   victim = fifo_use;
         default:    victim = lru_v;
      endcase
   end

   assign outcome = hit_ff ? OUT_HIT : (fill_ff ? OUT_FILL : OUT_REPLACE);
   assign sts.is_hit   = valid_ff[page_ff];
   assign sts.is_fill  = used_ff < eff;
   assign sts.div_done = (policy_ff != POL_RANDOM) || (dcnt_ff == 5'd16);
   assign out_free   = !rvalid_ff || rsp_tready;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) pframe_rd_ff <= pframe_mem[page_in];
      if (cmd.commit && !hit_ff) pframe_mem[page_ff] <= frame_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) page_ff <= page_in;
      if (cmd.decide) begin
         hit_ff   <= sts.is_hit;
         fill_ff  <= !sts.is_hit && sts.is_fill;
         frame_ff <= sts.is_hit ? hit_frame : used_ff[FRAME_W-1:0];
         dq_ff    <= lfsr_next;
         drem_ff  <= '0;
      end
      if (cmd.div_step && dcnt_ff != 5'd16 && policy_ff == POL_RANDOM) begin
         dq_ff <= {dq_ff[14:0], 1'b0};
         drem_ff <= dtrial[CNT_W] ? {drem_ff[CNT_W-2:0], dq_ff[15]}
                                  : dtrial[CNT_W-1:0];
      end
      if (cmd.div_step && sts.div_done) frame_ff <= victim;
      if (cmd.commit) begin
         rdata_ff <= {9'd0, !hit_ff && !fill_ff,
                      (hit_ff || fill_ff) ? 8'd0 : owner_ff[frame_ff],
                      frame_ff, outcome};
         if (!hit_ff) owner_ff[frame_ff] <= page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= 2'd2;
         fcount_ff <= 5'd16;
         valid_ff  <= '0;
         used_ff   <= '0;
         fifo_ff   <= '0;
         lfsr_ff   <= 16'd1;
         dcnt_ff   <= '0;
         rvalid_ff <= 1'b0;
         for (int g = 0; g < FRAMES; g++) age_ff[g] <= '0;
      end else begin
         if (csr_we && csr_index == CSR_POLICY) policy_ff <= csr_wdata[1:0];
         if (csr_we && csr_index == CSR_FRAMES) fcount_ff <= csr_wdata;
         if (cmd.decide) dcnt_ff <= '0;
         if (cmd.div_step && dcnt_ff != 5'd16 && policy_ff == POL_RANDOM)
            dcnt_ff <= dcnt_ff + 5'd1;
         if (cmd.div_step && sts.div_done) begin
            if (policy_ff == POL_RANDOM) lfsr_ff <= lfsr_next;
            else if (policy_ff == POL_FIFO)
               fifo_ff <= (CNT_W'(fifo_use) + CNT_W'(1) >= used_ff)
                          ? '0 : fifo_use + FRAME_W'(1);
         end
         if (cmd.commit) begin
            rvalid_ff <= 1'b1;
            if (fill_ff) used_ff <= used_ff + CNT_W'(1);
            if (!hit_ff && !fill_ff) valid_ff[owner_ff[frame_ff]] <= 1'b0;
            valid_ff[page_ff] <= 1'b1;
            for (int g = 0; g < FRAMES; g++) begin
               if (FRAME_W'(g) == frame_ff) age_ff[g] <= '0;
               else if (CNT_W'(g) < used_ff &&
                        (fill_ff || age_ff[g] < age_ff[frame_ff]) &&
                        age_ff[g] != AGE_W'(FRAMES - 1))
                  age_ff[g] <= age_ff[g] + AGE_W'(1);
            end
         end else if (rsp_tready) begin
            rvalid_ff <= 1'b0;
         end
      end
   end

endmodule

>>> rtl/page_replacement_table_top.sv
// ----------------------------------------------------------------------------
// page_replacement_table_top: demand paging table with victim selection
// Looks up each page reference and allocates or replaces frames.
// ----------------------------------------------------------------------------
// Usage: each transaction on the req_ channel carries one page number. The
// block answers with exactly one transaction on the rsp_ channel giving the
// outcome (hit, fill of a free frame, or replacement), the frame that now
// holds the page and, on replacement, the evicted page.
// One reference is worked on at a time. A hit or a free fill passes through
// the read, decide and commit steps; the result register loads at commit and
// the next reference can be accepted once the block is back in idle. A
// replacement adds a victim search step, and under the random policy the
// modulo of the LFSR by the number of used frames runs in that step as a
// bit-serial divider. The page table memory is read at acceptance.
// The result register lets the next reference be accepted while a result
// still waits; if the receiver stalls, the following reference holds in the
// commit step until the register frees.
// Reset clears all valid bits, the count of used frames, FIFO pointer and
// LRU ages, sets the LFSR to one and restores policy LRU with sixteen frames.
// Configuration writes on csr_ belong only where no reference is in flight.
// ----------------------------------------------------------------------------
module page_replacement_table_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // virtual page
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // outcome, frame, evicted_page, evicted_valid
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [4:0]  csr_wdata
);
   import prt_pkg::*;

   prt_cmd_type cmd;
   prt_sts_type sts;
   logic        out_free;

   prt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .out_free   (out_free),
      .sts        (sts),
      .cmd        (cmd)
   );

   prt_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .page_in    (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the page replacement table
// Drives page references with random gaps and response stalls, keeps its own
// page table model under every policy and frame count, and checks each
// response transaction against the predicted outcome, frame and victim.
// ----------------------------------------------------------------------------
module testbench;
   import prt_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [1:0] POL_LRU = 2'd2;
   localparam logic [1:0] POL_THREE = 2'd3;

   typedef struct packed {
      logic       evicted_valid;
      logic [7:0] evicted_page;
      logic [3:0] frame;
      logic [1:0] outcome;
   } access_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [4:0]  csr_wdata = '0;

   page_replacement_table_top uut (.*);

   always #4 clock = ~clock;

   // Shadow copy of the block's tables and registers.
   logic [1:0]  mdl_policy;
   logic [4:0]  mdl_frames_cfg;
   logic        mdl_valid [PAGE_COUNT];
   logic [3:0]  mdl_page_frame [PAGE_COUNT];
   logic [7:0]  mdl_owner [FRAMES];
   int          mdl_used;
   int          mdl_fifo_ptr;
   logic [3:0]  mdl_age [FRAMES];
   logic [15:0] mdl_lfsr;

   access_result_type expected_accesses [$];
   int  fail_count = 0;
   bit  quiet_phase = 1'b0;   // no idling on either side while set
   int  idle_cycles = 0;

   function automatic void model_reset();
      mdl_policy = POL_LRU;
      mdl_frames_cfg = 5'd16;
      for (int p = 0; p < PAGE_COUNT; p++) begin
         mdl_valid[p] = 1'b0;
         mdl_page_frame[p] = '0;
      end
      for (int f = 0; f < FRAMES; f++) begin
         mdl_owner[f] = '0;
         mdl_age[f] = '0;
      end
      mdl_used = 0;
      mdl_fifo_ptr = 0;
      mdl_lfsr = 16'd1;
   endfunction

   // Make frame f the most recently used one among the occupied frames.
   function automatic void mark_recent(int f, bit is_new);
      for (int g = 0; g < mdl_used; g++) begin
         if (g != f && (is_new || mdl_age[g] < mdl_age[f]))
            if (mdl_age[g] < FRAMES - 1) mdl_age[g]++;
      end
      mdl_age[f] = '0;
   endfunction

   function automatic access_result_type predict_access(logic [7:0] page);
      access_result_type r;
      int eff;
      int f;
      r = '0;
      eff = (mdl_frames_cfg == 0) ? 1 : (mdl_frames_cfg > FRAMES ? FRAMES : mdl_frames_cfg);
      if (mdl_valid[page]) begin
         f = int'(mdl_page_frame[page]);
         mark_recent(f, 1'b0);
         r.outcome = OUT_HIT;
      end else if (mdl_used < eff) begin
         f = mdl_used;
         mdl_used++;
         mdl_owner[f] = page;
         mdl_page_frame[page] = f[3:0];
         mdl_valid[page] = 1'b1;
         mark_recent(f, 1'b1);
         r.outcome = OUT_FILL;
      end else begin
         f = 0;
         if (mdl_policy == POL_RANDOM) begin
            mdl_lfsr = (mdl_lfsr >> 1) ^ (mdl_lfsr[0] ? LFSR_TAPS : 16'h0);
            f = mdl_lfsr % mdl_used;
         end else if (mdl_policy == POL_FIFO) begin
            if (mdl_fifo_ptr >= mdl_used) mdl_fifo_ptr = 0;
            f = mdl_fifo_ptr;
            mdl_fifo_ptr = (mdl_fifo_ptr + 1) % mdl_used;
         end else begin
            for (int g = 1; g < mdl_used; g++)
               if (mdl_age[g] > mdl_age[f]) f = g;
         end
         r.evicted_page = mdl_owner[f];
         r.evicted_valid = 1'b1;
         mdl_valid[mdl_owner[f]] = 1'b0;
         mdl_owner[f] = page;
         mdl_page_frame[page] = f[3:0];
         mdl_valid[page] = 1'b1;
         mark_recent(f, 1'b0);
         r.outcome = OUT_REPLACE;
      end
      r.frame = f[3:0];
      return r;
   endfunction

   // Idle decision: taken with a probability of about 21 percent, none during quiet phases.
   function automatic bit take_gap();
      return !quiet_phase && ($urandom_range(99) < 21);
   endfunction

   // Response side: stall at random, check every accepted transaction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_accesses.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            access_result_type e;
            access_result_type a;
            e = expected_accesses.pop_front();
            a = access_result_type'(rsp_tdata[14:0]);
            if (a.outcome !== e.outcome) begin
               $display("%0t: outcome expected %0d actual %0d", $time, e.outcome, a.outcome);
               fail_count++;
            end
            if (a.frame !== e.frame) begin
               $display("%0t: frame expected %0d actual %0d", $time, e.frame, a.frame);
               fail_count++;
            end
            if (a.evicted_page !== e.evicted_page) begin
               $display("%0t: evicted_page expected %0d actual %0d", $time,
                        e.evicted_page, a.evicted_page);
               fail_count++;
            end
            if (a.evicted_valid !== e.evicted_valid) begin
               $display("%0t: evicted_valid expected %0d actual %0d", $time,
                        e.evicted_valid, a.evicted_valid);
               fail_count++;
            end
            if (rsp_tdata[23:15] !== '0) begin
               $display("%0t: padding expected 0 actual %h", $time, rsp_tdata[23:15]);
               fail_count++;
            end
         end
      end
   end

   always @(negedge clock) rsp_tready <= !reset && !take_gap();

   // Watchdog: cycles without any accepted transaction on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("page_replacement_table_top test failed");
         $finish;
      end
   end

   // Register writes happen only while the block is idle.
   task automatic write_csr(logic idx, logic [4:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_POLICY) mdl_policy = value[1:0];
      else mdl_frames_cfg = value;
   endtask

   // Wait until every response arrived, then let the pipeline settle.
   task automatic drain();
      while (expected_accesses.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // One request transaction; the expectation is queued at acceptance.
   // An optional fixed expectation from the directed table is compared too.
   task automatic send_page(logic [7:0] page, bit has_fixed, access_result_type fixed);
      access_result_type p;
      @(negedge clock);
      while (take_gap()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= page;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      p = predict_access(page);
      if (has_fixed && p !== fixed) begin
         $display("%0t: directed row expected %h predicted %h", $time, fixed, p);
         fail_count++;
      end
      expected_accesses.push_back(p);
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   typedef struct {
      logic [7:0]        page;
      bit                fixed;
      access_result_type res;
   } stim_row_type;

   stim_row_type directed [] = '{
      '{8'd0,   1'b1, '{1'b0, 8'd0, 4'd0, OUT_FILL}},
      '{8'd255, 1'b1, '{1'b0, 8'd0, 4'd1, OUT_FILL}},
      '{8'd0,   1'b1, '{1'b0, 8'd0, 4'd0, OUT_HIT}},
      '{8'd255, 1'b1, '{1'b0, 8'd0, 4'd1, OUT_HIT}},
      '{8'd85,  1'b1, '{1'b0, 8'd0, 4'd2, OUT_FILL}},
      '{8'd170, 1'b1, '{1'b0, 8'd0, 4'd3, OUT_FILL}},
      '{8'd1,   1'b0, '0},
      '{8'd170, 1'b0, '0}
   };

   // Short replacement sequence run under a given policy and frame count.
   task automatic policy_phase(logic [1:0] pol, logic [4:0] nframes, int count, int span);
      write_csr(CSR_POLICY, {3'b000, pol});
      write_csr(CSR_FRAMES, nframes);
      for (int i = 0; i < count; i++)
         send_page(8'($urandom_range(span)), 1'b0, '0);
      drain();
   endtask

   initial begin
      model_reset();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table under reset settings (LRU, sixteen frames).
      foreach (directed[i]) send_page(directed[i].page, directed[i].fixed, directed[i].res);
      drain();
      // Frame count lowered below the frames in use, then frame count zero.
      write_csr(CSR_FRAMES, 5'd1);
      send_page(8'd7, 1'b0, '0);
      drain();
      write_csr(CSR_FRAMES, 5'd0);
      send_page(8'd9, 1'b0, '0);
      drain();
      // Policy three acts as LRU, large count saturates, then each policy.
      write_csr(CSR_POLICY, {3'b000, POL_THREE});
      write_csr(CSR_FRAMES, 5'd31);
      for (int i = 0; i < 20; i++) send_page(8'd200 + i[7:0], 1'b0, '0);
      send_page(8'd0, 1'b0, '0);
      drain();

      // Random part: phases across policies and frame counts; page spans are
      // near the frame count in most phases, so hits and replacements both occur.
      quiet_phase = 1'b1;
      policy_phase(POL_FIFO, 5'd16, 50, 40);
      quiet_phase = 1'b0;
      policy_phase(POL_RANDOM, 5'd16, 60, 30);
      policy_phase(POL_LRU, 5'd4, 50, 8);     // lowered below frames used
      policy_phase(POL_FIFO, 5'd3, 50, 10);
      policy_phase(POL_RANDOM, 5'd31, 60, 255);
      policy_phase(POL_LRU, 5'd16, 60, 24);
      policy_phase(POL_THREE, 5'd1, 40, 20);
      policy_phase(POL_FIFO, 5'd0, 40, 255);
      policy_phase(POL_RANDOM, 5'd8, 50, 20);
      policy_phase(POL_LRU, 5'd16, 60, 255);

      if (fail_count == 0)
         $display("page_replacement_table_top test passed");
      else
         $display("page_replacement_table_top test failed");
      $finish;
   end

endmodule
